[rtl/qxm_pkg.sv]
// Package for the quad X motor mixer: fixed-point constants, sign tables,
// queue entry types and the front-end state type. No dependencies.
package qxm_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int Q_ONE            = 16384;
  localparam int ARM_PROJ         = 11585;
  localparam int YAW_MIN_ROOM     = 3277;
  localparam int IDEAL_CAP        = 8192;

  localparam int IN_W    = 16;
  localparam int THR_W   = 15;
  localparam int LVL_W   = 15;
  localparam int IDX_W   = 3;
  localparam int CNT_W   = 4;
  localparam int FN_W    = 24;
  localparam int CODE_W  = 3;
  localparam int MIX_W   = 19;
  localparam int DV_W    = MIX_W - 1;
  localparam int SCALE_W = 16;
  localparam int DIV_W   = DV_W + SCALE_W - 1;
  localparam int RIDX_W  = 2;

  localparam logic [RIDX_W-1:0] CFG_CHANNEL_COUNT     = 2'd0;
  localparam logic [RIDX_W-1:0] CFG_CHANNEL_FUNCTIONS = 2'd1;

  localparam logic [CODE_W-1:0] FN_MOTOR1 = 3'd1;
  localparam logic [CODE_W-1:0] FN_MOTOR4 = 3'd4;

  // Bit i set: motor i takes the negated axis.
  localparam logic [3:0] ROLL_NEG  = 4'b1001;
  localparam logic [3:0] PITCH_NEG = 4'b1010;
  localparam logic [3:0] YAW_NEG   = 4'b1100;

  typedef logic [LVL_W-1:0] level_t;
  typedef level_t [3:0] motor_levels_t;

  typedef struct packed {
    logic          valid;
    motor_levels_t levels;
  } mix_push_t;

  typedef struct packed {
    logic          empty;
    logic          full;
    motor_levels_t head;
  } mix_queue_status_t;

  typedef enum logic [2:0] {
    F_IDLE, F_ALLOW, F_SPAN, F_SETUP, F_DIV, F_SCALE, F_MUL, F_FIN
  } front_state_t;

endpackage

[rtl/qxm_cmd_if.sv]
// Command channel interface: roll, pitch, yaw and throttle beat.
// Depends on qxm_pkg for field widths.
interface qxm_cmd_if;
  import qxm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  roll_cmd;
  logic signed [IN_W-1:0]  pitch_cmd;
  logic signed [IN_W-1:0]  yaw_cmd;
  logic [THR_W-1:0]        throttle_cmd;
  modport source (output valid, roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, input ready);
  modport sink (input valid, roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, output ready);
endinterface

[rtl/qxm_lvl_if.sv]
// Result channel interface: one channel level beat.
// Depends on qxm_pkg for field widths.
interface qxm_lvl_if;
  import qxm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] channel_index;
  logic [LVL_W-1:0] motor_level;
  logic             last_channel;
  modport source (output valid, channel_index, motor_level, last_channel, input ready);
  modport sink (input valid, channel_index, motor_level, last_channel, output ready);
endinterface

[rtl/qxm_cfg_if.sv]
// Configuration write channel interface: register index and data beat.
// Depends on qxm_pkg for field widths.
interface qxm_cfg_if;
  import qxm_pkg::*;
  logic              valid;
  logic              ready;
  logic [RIDX_W-1:0] reg_index;
  logic [FN_W-1:0]   wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

[rtl/qxm_front.sv]
// Front end: captures commands and computes four motor levels over a short
// sequence with a two-lane radix-4 divider. Depends on qxm_pkg, qxm_cmd_if.
module qxm_front (
  input  logic                         clk,
  input  logic                         rst,
  qxm_cmd_if.sink                      cmd,
  input  logic                         q_full,
  output qxm_pkg::mix_push_t           push
);
  import qxm_pkg::*;

  front_state_t state, state_next;

  logic                    hold_valid;
  logic signed [IN_W-1:0]  h_roll, h_pitch, h_yaw;
  logic [THR_W-1:0]        h_thr;

  logic signed [IN_W-1:0]  yaw_in;
  logic signed [MIX_W-1:0] yaw_w;
  logic [THR_W-1:0]        thr;
  logic signed [MIX_W-1:0] mix [4];
  logic signed [MIX_W-1:0] scaled [4];
  logic signed [MIX_W-1:0] rmax, rmin, smax, smin;
  logic [DIV_W-1:0]        rem_a, rem_b;
  logic [DV_W-1:0]         d_a, d_b;
  logic [SCALE_W-1:0]      q_a, q_b, scale;
  logic                    use_a, use_b;
  logic [2:0]              step;

  function automatic logic signed [MIX_W-1:0] arm_mix(
    input logic signed [IN_W-1:0] r, input logic signed [IN_W-1:0] p,
    input logic rn, input logic pn);
    logic signed [IN_W+1:0] re, pe, sum;
    logic [IN_W:0]          mag;
    logic [30:0]            prod;
    logic [IN_W:0]          rnd;
    re   = rn ? -(IN_W+2)'(r) : (IN_W+2)'(r);
    pe   = pn ? -(IN_W+2)'(p) : (IN_W+2)'(p);
    sum  = re + pe;
    mag  = sum[IN_W+1] ? (IN_W+1)'(-sum) : (IN_W+1)'(sum);
    prod = 31'(mag) * 31'(ARM_PROJ);
    rnd  = (IN_W+1)'((prod + 31'(Q_ONE / 2)) >> 14);
    return sum[IN_W+1] ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
  endfunction

  // Scale by Q1.14 factor, truncating toward zero.
  function automatic logic signed [MIX_W-1:0] tmul(
    input logic signed [MIX_W-1:0] v, input logic [SCALE_W-1:0] s);
    logic [DV_W-1:0]         mag;
    logic [DV_W+SCALE_W-1:0] p;
    logic [DV_W-1:0]         t;
    mag = v[MIX_W-1] ? DV_W'(-v) : DV_W'(v);
    p   = (DV_W+SCALE_W)'(mag) * (DV_W+SCALE_W)'(s);
    t   = DV_W'(p >> 14);
    return v[MIX_W-1] ? -$signed({1'b0, t}) : $signed({1'b0, t});
  endfunction

  // Two restoring steps: quotient bits 2k+1 and 2k.
  function automatic logic [DIV_W+1:0] div2(
    input logic [DIV_W-1:0] rem, input logic [DV_W-1:0] d, input logic [2:0] k);
    logic [DIV_W-1:0] t1, t0, r1, r0;
    logic             b1, b0;
    t1 = DIV_W'(d) << {k, 1'b1};
    b1 = rem >= t1;
    r1 = b1 ? rem - t1 : rem;
    t0 = DIV_W'(d) << {k, 1'b0};
    b0 = r1 >= t0;
    r0 = b0 ? r1 - t0 : r1;
    return {b1, b0, r0};
  endfunction

  logic signed [MIX_W-1:0] yaw_clip;
  logic signed [MIX_W-1:0] mix_y [4];
  logic signed [MIX_W-1:0] rmax_c, rmin_c;
  logic [DIV_W+1:0]        st_a, st_b;
  motor_levels_t           lvl_c;

  always_comb begin
    logic [THR_W-1:0]        ideal;
    logic signed [MIX_W-1:0] pred, room, allowed, yaw_x, ymix, base, adj, lim, fin, v;
    logic                    add_side;
    ideal   = (thr > THR_W'(IDEAL_CAP)) ? THR_W'(IDEAL_CAP) : thr;
    allowed = MIX_W'(Q_ONE);
    yaw_x   = MIX_W'(yaw_in);
    for (int i = 0; i < 4; i++) begin
      pred     = $signed({4'b0, ideal}) + mix[i];
      add_side = YAW_NEG[i] ? (yaw_in <= 0) : (yaw_in >= 0);
      room     = add_side ? MIX_W'(Q_ONE) - pred : pred;
      if (room < 0) room = '0;
      if (room < allowed) allowed = room;
    end
    if (allowed < MIX_W'(YAW_MIN_ROOM)) allowed = MIX_W'(YAW_MIN_ROOM);
    yaw_clip = yaw_x;
    if (yaw_x > allowed) yaw_clip = allowed;
    if (yaw_x < -allowed) yaw_clip = -allowed;

    rmax_c = '0;
    rmin_c = MIX_W'(Q_ONE);
    for (int i = 0; i < 4; i++) begin
      ymix      = YAW_NEG[i] ? -yaw_w : yaw_w;
      mix_y[i]  = mix[i] + ymix;
      if (mix_y[i] > rmax_c) rmax_c = mix_y[i];
      if (mix_y[i] < rmin_c) rmin_c = mix_y[i];
    end

    st_a = div2(rem_a, d_a, step);
    st_b = div2(rem_b, d_b, step);

    base = smin[MIX_W-1] ? -smin : smin;
    adj  = $signed({4'b0, thr}) - base;
    lim  = MIX_W'(Q_ONE) - base - smax;
    if (scale < SCALE_W'(Q_ONE)) adj = '0;
    else if (adj < 0) adj = '0;
    else if (adj > lim) adj = lim;
    fin = base + adj;
    for (int i = 0; i < 4; i++) begin
      v = fin + scaled[i];
      if (v < 0) v = '0;
      if (v > MIX_W'(Q_ONE)) v = MIX_W'(Q_ONE);
      lvl_c[i] = LVL_W'(v);
    end
  end

  assign cmd.ready   = !hold_valid;
  assign push.valid  = (state == F_FIN);
  assign push.levels = lvl_c;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (hold_valid) state_next = F_ALLOW;
      F_ALLOW: state_next = F_SPAN;
      F_SPAN:  state_next = F_SETUP;
      F_SETUP: state_next = F_DIV;
      F_DIV:   if (step == 3'd0) state_next = F_SCALE;
      F_SCALE: state_next = F_MUL;
      F_MUL:   state_next = F_FIN;
      F_FIN:   if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      hold_valid <= 1'b1;
    end else if (state == F_IDLE) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      h_roll  <= cmd.roll_cmd;
      h_pitch <= cmd.pitch_cmd;
      h_yaw   <= cmd.yaw_cmd;
      h_thr   <= cmd.throttle_cmd;
    end
    unique case (state)
      F_IDLE: begin
        for (int i = 0; i < 4; i++) mix[i] <= arm_mix(h_roll, h_pitch, ROLL_NEG[i], PITCH_NEG[i]);
        yaw_in <= h_yaw;
        thr    <= h_thr;
      end
      F_ALLOW: yaw_w <= yaw_clip;
      F_SPAN: begin
        for (int i = 0; i < 4; i++) mix[i] <= mix_y[i];
        rmax <= rmax_c;
        rmin <= rmin_c;
      end
      F_SETUP: begin
        use_a <= (rmax - rmin) >= MIX_W'(Q_ONE);
        use_b <= ($signed({4'b0, thr}) + rmin) < 0;
        d_a   <= DV_W'(rmax - rmin);
        d_b   <= rmin[MIX_W-1] ? DV_W'(-rmin) : DV_W'(rmin);
        rem_a <= DIV_W'(Q_ONE) * DIV_W'(Q_ONE);
        rem_b <= DIV_W'(thr) * DIV_W'(Q_ONE);
        q_a   <= '0;
        q_b   <= '0;
        step  <= 3'd7;
      end
      F_DIV: begin
        rem_a <= st_a[DIV_W-1:0];
        rem_b <= st_b[DIV_W-1:0];
        q_a   <= {q_a[SCALE_W-3:0], st_a[DIV_W+1:DIV_W]};
        q_b   <= {q_b[SCALE_W-3:0], st_b[DIV_W+1:DIV_W]};
        step  <= step - 3'd1;
      end
      F_SCALE: begin
        if (use_b && (!use_a || q_b < q_a) && q_b < SCALE_W'(Q_ONE)) scale <= q_b;
        else if (use_a) scale <= q_a;
        else scale <= SCALE_W'(Q_ONE);
      end
      F_MUL: begin
        for (int i = 0; i < 4; i++) scaled[i] <= tmul(mix[i], scale);
        smax <= tmul(rmax, scale);
        smin <= tmul(rmin, scale);
      end
      F_FIN: ;
      default: ;
    endcase
  end

endmodule

[rtl/qxm_queue.sv]
// Two-entry queue of motor level sets between front and back end.
// Depends on qxm_pkg.
module qxm_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  qxm_pkg::mix_push_t            push,
  input  logic                          pop,
  output qxm_pkg::mix_queue_status_t    status
);
  import qxm_pkg::*;

  motor_levels_t mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          do_push;

  assign do_push       = push.valid && (count != 2'd2);
  assign status.empty  = (count == 2'd0);
  assign status.full   = (count == 2'd2);
  assign status.head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (pop)     rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push.levels;
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("queue popped while empty");

endmodule

[rtl/qxm_back.sv]
// Back end: walks the configured channels for each level set and drives the
// registered result channel. Depends on qxm_pkg, qxm_lvl_if.
module qxm_back #(
  parameter int MAX_CHANNELS = qxm_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  qxm_pkg::mix_queue_status_t       status,
  output logic                             pop,
  input  logic [qxm_pkg::CNT_W-1:0]        channel_count,
  input  logic [qxm_pkg::FN_W-1:0]         channel_functions,
  qxm_lvl_if.source                        lvl
);
  import qxm_pkg::*;

  logic [IDX_W-1:0]  k;
  logic [CNT_W-1:0]  cnt;
  logic [CODE_W-1:0] code;
  logic              emit, is_last;
  logic              ov;
  logic [IDX_W-1:0]  o_idx;
  logic [LVL_W-1:0]  o_lvl;
  logic              o_last;

  assign cnt     = (channel_count > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : channel_count;
  assign code    = channel_functions[CODE_W*k +: CODE_W];
  assign is_last = (CNT_W'(k) + CNT_W'(1)) == cnt;
  assign emit    = !status.empty && (cnt != '0) && (!ov || lvl.ready);
  // Drop a level set at once when no channel is configured.
  assign pop     = !status.empty && ((cnt == '0) || (emit && is_last));

  assign lvl.valid         = ov;
  assign lvl.channel_index = o_idx;
  assign lvl.motor_level   = o_lvl;
  assign lvl.last_channel  = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      k  <= '0;
    end else begin
      if (emit) begin
        ov <= 1'b1;
        k  <= is_last ? '0 : k + IDX_W'(1);
      end else if (lvl.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_idx  <= k;
      o_last <= is_last;
      o_lvl  <= (code >= FN_MOTOR1 && code <= FN_MOTOR4) ?
                status.head[2'(code - FN_MOTOR1)] : '0;
    end
  end

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    (ov && o_last) |-> (CNT_W'(o_idx) + CNT_W'(1)) == cnt)
    else $error("last channel flag on wrong channel");
  a_emit_src: assert property (@(posedge clk) disable iff (rst) emit |-> !status.empty)
    else $error("emit with no level set");
  a_reset_idle: assert property (@(posedge clk) rst |=> !ov)
    else $error("result valid after reset");

endmodule

[rtl/quad_x_motor_mixer.sv]
// Quad X motor mixer top level: config registers, front end, queue, back end.
// Depends on qxm_pkg, the three channel interfaces and the qxm_* modules.
//
// Takes one roll, pitch, yaw and throttle command (Q1.14) per beat and emits
// one beat per configured output channel, channels 0 upward, with the last
// beat flagged. Levels are the X-quad mix with yaw headroom, span scaling and
// throttle shift, saturated to [0,1]. The front end runs each command through
// a sequence around a two-lane radix-4 divider; the back end emits one channel
// per cycle unless the result channel stalls. A two-entry queue lets the front
// work on the next command while channels of the previous one drain, and a
// command capture register takes a new beat while the front is busy. At most
// MAX_CHANNELS channels, eight by default, are emitted per level set (a zero
// channel count drops the level set at once). Configuration writes are always
// ready and take effect at once; write them only while idle. Writes to unused
// indexes are ignored.
module quad_x_motor_mixer #(
  parameter int MAX_CHANNELS = qxm_pkg::MAX_CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  qxm_cmd_if.sink   cmd,
  qxm_cfg_if.sink   cfg,
  qxm_lvl_if.source lvl
);
  import qxm_pkg::*;

  logic [CNT_W-1:0]  channel_count;
  logic [FN_W-1:0]   channel_functions;
  mix_push_t         push;
  mix_queue_status_t status;
  logic              pop;

  // Config writes never stall.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count     <= CNT_W'(4);
      channel_functions <= FN_W'(2257);
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        CFG_CHANNEL_COUNT:     channel_count     <= cfg.wr_data[CNT_W-1:0];
        CFG_CHANNEL_FUNCTIONS: channel_functions <= cfg.wr_data;
        default: ;
      endcase
    end
  end

  qxm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .q_full (status.full),
    .push   (push)
  );

  qxm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .status (status)
  );

  qxm_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk               (clk),
    .rst               (rst),
    .status            (status),
    .pop               (pop),
    .channel_count     (channel_count),
    .channel_functions (channel_functions),
    .lvl               (lvl)
  );

endmodule
